### rtl/core/sssp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sssp_pkg
// shared types and constants of the stepper speed slew / step period core
// ---------------------------------------------------------------------------
package sssp_pkg;

    localparam int MOTOR_W = 1;
    localparam int SPEED_W = 16;
    localparam int ACCEL_W = 15;
    localparam int PERIOD_W = 24;
    localparam int SCALE_W = 8;
    localparam int TICK_W = 27;
    localparam int PROD_W = SPEED_W + SCALE_W + 1;
    localparam int MAG_W = PROD_W - 1;
    localparam int DIV_STEPS = TICK_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int DIR_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = TICK_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_NUMERATOR = 3'd3;

    // register reset values
    localparam logic [ACCEL_W-1:0] SLEW_STEP_RST = 15'd8;
    localparam logic [PERIOD_W-1:0] IDLE_PERIOD_RST = 24'd65535;
    localparam logic [SCALE_W-1:0] STEP_SCALE_RST = 8'd25;
    localparam logic [TICK_W-1:0] TICK_NUMERATOR_RST = 27'd2000000;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic signed [SPEED_W-1:0] target_speed;
    } in_item_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_out;
        logic signed [SPEED_W-1:0] current_speed;
        logic [DIR_W-1:0] direction;
        logic [PERIOD_W-1:0] step_period;
    } out_item_t;

    typedef struct packed {
        logic [ACCEL_W-1:0] slew_step;
        logic [PERIOD_W-1:0] idle_period;
        logic [SCALE_W-1:0] step_scale;
        logic [TICK_W-1:0] tick_numerator;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic slew;
        logic mul;
        logic prep;
        logic div_step;
        logic out_load;
    } cmd_t;

endpackage

### rtl/core/sssp_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sssp channel interfaces
// valid/ready stream channel and configuration write channel
// ---------------------------------------------------------------------------
interface sssp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sssp_cfg_if;
    logic valid;
    logic ready;
    logic [sssp_pkg::CFG_IDX_W-1:0] index;
    logic [sssp_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/core/sssp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sssp_ctrl
// sequencer: slew, multiply, divide and result hand-off
// ---------------------------------------------------------------------------
module sssp_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output sssp_pkg::cmd_t cmd
);
    import sssp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLEW = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_FIN = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_in = 1'b1;
                    state_next = S_SLEW;
                end
            end
            S_SLEW:
            begin
                cmd.slew = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_slew: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_SLEW))
        else $error("accepted request did not start the slew step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over one not yet taken");

    a_div_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divide step count out of range");

    a_div_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> (state_reg == S_FIN))
        else $error("divide did not finish after the last step");
`endif

endmodule

### rtl/core/sssp_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sssp_dp
// speed store, slew limit, scale multiply, restoring divider, result register
// ---------------------------------------------------------------------------
module sssp_dp #(
    parameter int NUM_MOTORS = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  sssp_pkg::cmd_t cmd,
    input  sssp_pkg::cfg_t cfg,
    input  sssp_pkg::in_item_t in_item,
    output sssp_pkg::out_item_t out_item
);
    import sssp_pkg::*;

    logic signed [SPEED_W-1:0] speed_reg [NUM_MOTORS];
    logic [MOTOR_W-1:0] motor_reg;
    logic signed [SPEED_W-1:0] target_reg;
    logic signed [SPEED_W-1:0] spd_reg, spd_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [DIR_W-1:0] dir_reg;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [TICK_W-1:0] quo_reg, quo_next;
    out_item_t out_reg;

    logic motor_ok;
    logic signed [SPEED_W-1:0] spd_cur;
    logic signed [SPEED_W:0] diff, acc, spd_ext, tgt_ext, spd_dn, spd_up;
    logic signed [PROD_W-1:0] prod_neg;
    logic [MAG_W:0] rem_sh, rem_sub;
    logic rem_ge;
    logic [TICK_W-1:0] quo_min1;
    logic [PERIOD_W-1:0] period;

    assign motor_ok = (32'(motor_reg) < NUM_MOTORS);

    // slew limit
    always_comb
    begin
        spd_cur = '0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            if (32'(motor_reg) == i)
            begin
                spd_cur = speed_reg[i];
            end
        end
        spd_ext = {spd_cur[SPEED_W-1], spd_cur};
        tgt_ext = {target_reg[SPEED_W-1], target_reg};
        acc = {2'b00, cfg.slew_step};
        diff = spd_ext - tgt_ext;
        spd_dn = spd_ext - acc;
        spd_up = spd_ext + acc;
        if (!motor_ok)
        begin
            spd_next = '0;
        end
        else if (diff > acc)
        begin
            spd_next = spd_dn[SPEED_W-1:0];
        end
        else if (diff < -acc)
        begin
            spd_next = spd_up[SPEED_W-1:0];
        end
        else
        begin
            spd_next = target_reg;
        end
    end

    // one quotient bit a step
    assign prod_neg = -prod_reg;
    assign rem_sh = {rem_reg, quo_reg[TICK_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, mag_reg});
    assign rem_sub = rem_sh - {1'b0, mag_reg};
    assign rem_next = rem_ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
    assign quo_next = {quo_reg[TICK_W-2:0], rem_ge};

    // period clamp
    always_comb
    begin
        quo_min1 = (quo_reg == '0) ? TICK_W'(1) : quo_reg;
        if (dir_reg == DIR_STOP)
        begin
            period = cfg.idle_period;
        end
        else if (quo_min1 > {{(TICK_W - PERIOD_W){1'b0}}, cfg.idle_period})
        begin
            period = cfg.idle_period;
        end
        else
        begin
            period = quo_min1[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                speed_reg[i] <= '0;
            end
        end
        else if (cmd.slew && motor_ok)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                if (32'(motor_reg) == i)
                begin
                    speed_reg[i] <= spd_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            motor_reg <= in_item.motor;
            target_reg <= in_item.target_speed;
        end
        if (cmd.slew)
        begin
            spd_reg <= spd_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(spd_reg) * PROD_W'($signed({1'b0, cfg.step_scale}));
        end
        if (cmd.prep)
        begin
            mag_reg <= prod_reg[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_reg[MAG_W-1:0];
            if (prod_reg == '0)
            begin
                dir_reg <= DIR_STOP;
            end
            else if (prod_reg[PROD_W-1])
            begin
                dir_reg <= DIR_REV;
            end
            else
            begin
                dir_reg <= DIR_FWD;
            end
            rem_reg <= '0;
            quo_reg <= cfg.tick_numerator;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            out_reg.motor_out <= motor_reg;
            out_reg.current_speed <= spd_reg;
            out_reg.direction <= dir_reg;
            out_reg.step_period <= period;
        end
    end

    assign out_item = out_reg;

endmodule

### rtl/core/stepper_speed_slew_to_period_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_speed_slew_to_period_core
// per-motor speed slew limiter with scaled-speed to step-period conversion
// ---------------------------------------------------------------------------
//
//  channel  | dir  | payload                                      | handshake
//  ---------+------+----------------------------------------------+----------
//  in_ch    | sink | motor, target_speed                          | valid/ready
//  out_ch   | src  | motor_out, current_speed, direction,         | valid/ready
//           |      | step_period                                  |
//  cfg      | sink | index, wdata (register write)                | valid/ready
//
//  after a request is accepted it passes the slew step, the multiply, the
//  magnitude step, the restoring divider (one quotient bit a cycle, over the
//  27 bit tick numerator) and the load of the output register, in that
//  order
//  one request in flight at a time; in_ch.ready is high only when idle
//  a held result stalls only the final load, the divide runs on regardless
//  reset clears the speed of every motor and loads the default registers
//  cfg.ready is always high; writes are expected while idle
// ---------------------------------------------------------------------------
module stepper_speed_slew_to_period_core #(
    parameter int NUM_MOTORS = 2
) (
    input  logic clk,
    input  logic rst_n,
    sssp_stream_if.sink in_ch,
    sssp_stream_if.source out_ch,
    sssp_cfg_if.sink cfg
);
    import sssp_pkg::*;

    // configuration registers
    cfg_t cfg_reg;
    cmd_t cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slew_step <= SLEW_STEP_RST;
            cfg_reg.idle_period <= IDLE_PERIOD_RST;
            cfg_reg.step_scale <= STEP_SCALE_RST;
            cfg_reg.tick_numerator <= TICK_NUMERATOR_RST;
        end
        else if (cfg.valid)
        begin
            // masked to each register width; unknown indexes fall through
            unique case (cfg.index)
                REG_SLEW_STEP:
                begin
                    cfg_reg.slew_step <= cfg.wdata[ACCEL_W-1:0];
                end
                REG_IDLE_PERIOD:
                begin
                    cfg_reg.idle_period <= cfg.wdata[PERIOD_W-1:0];
                end
                REG_STEP_SCALE:
                begin
                    cfg_reg.step_scale <= cfg.wdata[SCALE_W-1:0];
                end
                REG_TICK_NUMERATOR:
                begin
                    cfg_reg.tick_numerator <= cfg.wdata[TICK_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    sssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // speed store, multiply, divide and result register
    sssp_dp #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_item  (in_ch.data),
        .out_item (out_ch.data)
    );

endmodule
